>>> sv/bbq_pkg.sv
// Shared types, constants and result codes for the box overlap query block.
`timescale 1ns / 1ps
`default_nettype none
package bbq_pkg;

  localparam int NODE_COUNT_DEF  = 1024;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF  = 32;

  // Root register reset value: empty tree
  localparam logic [10:0] ROOT_RESET = 11'd1024;

  // Closing and hit status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_ABORT = 2'd3;

  // Action codes on the request channel
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Normalized command passed from front to back
  typedef struct packed {
    logic               query;
    logic [9:0]         idx;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] lz;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] hz;
    logic [10:0]        left;
    logic [10:0]        right;
    logic [5:0]         limit;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [9:0] hit_node;
    logic [5:0] hit_count;
    logic [1:0] status;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> sv/bbq_if.sv
// Request and response channel interfaces for the box overlap query block.
`timescale 1ns / 1ps
`default_nettype none
interface bbq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [9:0]         node_index;
  logic signed [31:0] min_x;
  logic signed [31:0] min_y;
  logic signed [31:0] min_z;
  logic signed [31:0] max_x;
  logic signed [31:0] max_y;
  logic signed [31:0] max_z;
  logic [10:0]        left_child;
  logic [10:0]        right_child;
  logic [5:0]         hit_limit;

  modport source (output valid, action, node_index, min_x, min_y, min_z,
                  max_x, max_y, max_z, left_child, right_child, hit_limit,
                  input ready);
  modport sink (input valid, action, node_index, min_x, min_y, min_z,
                max_x, max_y, max_z, left_child, right_child, hit_limit,
                output ready);
endinterface

interface bbq_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] hit_node;
  logic [5:0] hit_count;
  logic [1:0] status;
  logic       last;

  modport source (output valid, hit_node, hit_count, status, last, input ready);
  modport sink (input valid, hit_node, hit_count, status, last, output ready);
endinterface
`default_nettype wire

>>> sv/bbq_front.sv
// Front end: accepts items, normalizes coordinates, drops bad writes, queues commands.
`timescale 1ns / 1ps
`default_nettype none
module bbq_front #(
  parameter int NODE_COUNT = bbq_pkg::NODE_COUNT_DEF,
  parameter int COORD_BITS = bbq_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  bbq_in_if.sink             req,
  output logic               cq_valid,
  input  wire logic          cq_ready,
  output bbq_pkg::cmd_t      cq_cmd
);

  bbq_pkg::cmd_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  bbq_pkg::cmd_t cmd;
  logic          drop;
  logic          push;
  logic          pop;

  // Take low COORD_BITS and sign extend
  function automatic logic signed [31:0] sx(input logic [31:0] v);
    logic signed [COORD_BITS-1:0] t;
    t = v[COORD_BITS-1:0];
    return 32'(t);
  endfunction

  // Classify and normalize the incoming item
  always_comb begin
    cmd.query = (req.action == bbq_pkg::ACT_QUERY);
    cmd.idx   = req.node_index;
    cmd.lx    = sx(req.min_x);
    cmd.ly    = sx(req.min_y);
    cmd.lz    = sx(req.min_z);
    cmd.hx    = sx(req.max_x);
    cmd.hy    = sx(req.max_y);
    cmd.hz    = sx(req.max_z);
    cmd.left  = req.left_child;
    cmd.right = req.right_child;
    cmd.limit = req.hit_limit;
  end

  // Writes past the node memory are ignored
  assign drop = (req.action == bbq_pkg::ACT_WRITE) && (32'(req.node_index) >= NODE_COUNT);

  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready && !drop;
  assign pop       = cq_valid && cq_ready;
  assign cq_valid  = (cnt != 2'd0);
  assign cq_cmd    = q[rp];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q[wp] <= cmd;
        wp    <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> sv/bbq_walk.sv
// Back end: node memory, walk stack and the depth-first overlap walk.
`timescale 1ns / 1ps
`default_nettype none
module bbq_walk #(
  parameter int NODE_COUNT  = bbq_pkg::NODE_COUNT_DEF,
  parameter int STACK_DEPTH = bbq_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = bbq_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [10:0]   root,
  input  wire logic          cq_valid,
  output logic               cq_ready,
  input  wire bbq_pkg::cmd_t cq_cmd,
  bbq_out_if.source          rsp
);

  localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MCW = $clog2(STACK_DEPTH + 1);
  localparam int PW  = $clog2(2 * NODE_COUNT + 2);
  localparam logic [PW-1:0] BUDGET = PW'(2 * NODE_COUNT + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_STK   = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
    logic signed [COORD_BITS-1:0] lz;
    logic signed [COORD_BITS-1:0] hx;
    logic signed [COORD_BITS-1:0] hy;
    logic signed [COORD_BITS-1:0] hz;
    logic [10:0]                  l;
    logic [10:0]                  r;
  } node_t;

  node_t         nmem [NODE_COUNT];
  logic [10:0]   smem [STACK_DEPTH];
  node_t         nd;
  logic [10:0]   stk_q;

  logic [2:0]    st;
  bbq_pkg::cmd_t qb;
  logic [MCW-1:0] mcnt;
  logic          tv;
  logic [10:0]   top;
  logic [10:0]   cur;
  logic [PW-1:0] pops;
  logic [5:0]    cnt;
  logic [1:0]    status;
  logic          ov;
  bbq_pkg::res_t ores;

  logic [10:0]    cand;
  logic [31:0]    cand_ext;
  logic           cand_ok;
  logic           root_ok;
  logic           pop_go;
  logic           n_re;
  logic           n_we;
  node_t          n_wdata;
  logic [NAW-1:0] n_waddr;
  logic [31:0]    widx_ext;
  logic           s_we;
  logic           s_re;
  logic [MCW-1:0] mm1;
  logic           ovl;
  logic           leaf;
  logic           fits;
  logic           out_free;
  logic           ov_load;
  logic [6:0]     cnt_inc;

  // Candidate node: register top or the word just read from the stack
  assign cand     = (st == S_STK) ? stk_q : top;
  assign cand_ext = 32'(cand);
  assign cand_ok  = cand_ext < NODE_COUNT;
  assign root_ok  = 32'(root) < NODE_COUNT;
  assign mm1      = mcnt - 1'b1;
  assign pop_go   = (st == S_POP) && (tv || (mcnt != '0)) && (pops != BUDGET);
  assign n_re     = (pop_go && tv && cand_ok) || ((st == S_STK) && cand_ok);
  assign s_re     = pop_go && !tv;

  // Overlap test, inclusive on every axis
  always_comb begin
    ovl = (32'(nd.lx) <= qb.hx) && (32'(nd.hx) >= qb.lx) &&
          (32'(nd.ly) <= qb.hy) && (32'(nd.hy) >= qb.ly) &&
          (32'(nd.lz) <= qb.hz) && (32'(nd.hz) >= qb.lz);
  end
  assign leaf     = 32'(nd.l) >= NODE_COUNT;
  assign fits     = (32'(mcnt) + 32'd2) <= STACK_DEPTH;
  assign s_we     = (st == S_TEST) && ovl && !leaf && fits;
  assign out_free = !ov || rsp.ready;
  assign ov_load  = out_free && (((st == S_TEST) && ovl && leaf) || (st == S_CLOSE));
  assign cnt_inc  = 7'(cnt) + 7'd1;

  // Node writes come straight from the command queue
  assign cq_ready = (st == S_IDLE);
  assign n_we     = (st == S_IDLE) && cq_valid && !cq_cmd.query;
  assign widx_ext = 32'(cq_cmd.idx);
  assign n_waddr  = widx_ext[NAW-1:0];
  always_comb begin
    n_wdata.lx = cq_cmd.lx[COORD_BITS-1:0];
    n_wdata.ly = cq_cmd.ly[COORD_BITS-1:0];
    n_wdata.lz = cq_cmd.lz[COORD_BITS-1:0];
    n_wdata.hx = cq_cmd.hx[COORD_BITS-1:0];
    n_wdata.hy = cq_cmd.hy[COORD_BITS-1:0];
    n_wdata.hz = cq_cmd.hz[COORD_BITS-1:0];
    n_wdata.l  = cq_cmd.left;
    n_wdata.r  = cq_cmd.right;
  end

  // Node memory
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    if (n_re) nd <= nmem[cand_ext[NAW-1:0]];
  end

  // Walk stack memory; the top entry lives in a register
  always_ff @(posedge clk) begin
    if (s_we) smem[mcnt[SAW-1:0]] <= nd.l;
    if (s_re) stk_q <= smem[mm1[SAW-1:0]];
  end

  // Output item register valid: load wins over drain
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (ov_load) ov <= 1'b1;
    else if (rsp.ready) ov <= 1'b0;
  end

  // Walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      mcnt <= '0;
      tv   <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (cq_valid && cq_cmd.query) begin
            qb     <= cq_cmd;
            cnt    <= 6'd0;
            pops   <= '0;
            status <= bbq_pkg::ST_DONE;
            mcnt   <= '0;
            tv     <= root_ok;
            top    <= root;
            st     <= S_POP;
          end
        end
        S_POP: begin
          if (!tv && mcnt == '0) begin
            st <= S_CLOSE;
          end else if (pops == BUDGET) begin
            status <= bbq_pkg::ST_ABORT;
            st     <= S_CLOSE;
          end else begin
            pops <= pops + 1'b1;
            if (tv) begin
              tv  <= 1'b0;
              cur <= cand;
              st  <= cand_ok ? S_TEST : S_POP;
            end else begin
              mcnt <= mm1;
              st   <= S_STK;
            end
          end
        end
        S_STK: begin
          cur <= cand;
          st  <= cand_ok ? S_TEST : S_POP;
        end
        S_TEST: begin
          if (!ovl) begin
            st <= S_POP;
          end else if (leaf) begin
            if (out_free) begin
              ores.hit_node  <= cur[9:0];
              ores.hit_count <= cnt_inc[5:0];
              ores.status    <= bbq_pkg::ST_HIT;
              ores.last      <= 1'b0;
              cnt            <= cnt_inc[5:0];
              if (cnt_inc >= 7'(qb.limit)) begin
                status <= bbq_pkg::ST_LIMIT;
                st     <= S_CLOSE;
              end else begin
                st <= S_POP;
              end
            end
          end else if (!fits) begin
            status <= bbq_pkg::ST_ABORT;
            st     <= S_CLOSE;
          end else begin
            mcnt <= mcnt + 1'b1;
            tv   <= 1'b1;
            top  <= nd.r;
            st   <= S_POP;
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            ores.hit_node  <= 10'd0;
            ores.hit_count <= cnt;
            ores.status    <= status;
            ores.last      <= 1'b1;
            mcnt           <= '0;
            tv             <= 1'b0;
            st             <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = ov;
  assign rsp.hit_node  = ores.hit_node;
  assign rsp.hit_count = ores.hit_count;
  assign rsp.status    = ores.status;
  assign rsp.last      = ores.last;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> (mcnt == '0 && !tv))
    else $error("stack not empty between queries");
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    32'(mcnt) <= STACK_DEPTH)
    else $error("stack fill past its depth");
  a_pop_bound: assert property (@(posedge clk) disable iff (rst)
    (st != S_IDLE) |-> (pops <= BUDGET))
    else $error("pop count past budget");
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (st == S_TEST && ovl && leaf && out_free) |=> (cnt == $past(cnt) + 6'd1))
    else $error("hit count did not advance on a hit");
`endif

endmodule
`default_nettype wire

>>> sv/bvh_box_overlap_query.sv
// Top level of the bounding-volume tree box overlap query block.
`timescale 1ns / 1ps
`default_nettype none
// Write items store tree nodes in the back end and give no result. A query
// item walks the tree depth first from the root register and returns one item
// per overlapping leaf, up to its hit limit or an abort, and then a closing
// item. The walk runs as a state sequence: taking the query leads to a pop, a
// pop of an entry held in stack memory (rather than the top register) passes
// through a stack read state, and an in-range node then passes through the
// overlap test on the word read from node memory; a skipped out-of-range child
// goes back to the pop state. Finding the stack empty leads to the closing item;
// a hit or the closing item waits while the output register is still held by
// the sink. Query time follows the number of entries popped. A two-entry command
// queue lets new items be accepted while a walk runs. No clearing pass follows
// reset.
module bvh_box_overlap_query #(
  parameter int NODE_COUNT  = bbq_pkg::NODE_COUNT_DEF,
  parameter int STACK_DEPTH = bbq_pkg::STACK_DEPTH_DEF,
  parameter int COORD_BITS  = bbq_pkg::COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  bbq_in_if.sink           req,
  bbq_out_if.source        rsp
);

  logic [10:0]   root;
  logic          cq_valid;
  logic          cq_ready;
  bbq_pkg::cmd_t cq_cmd;

  // Root register
  always_ff @(posedge clk) begin
    if (rst) root <= bbq_pkg::ROOT_RESET;
    else if (cfg_we) root <= cfg_wdata;
  end

  bbq_front #(
    .NODE_COUNT (NODE_COUNT),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cq_valid (cq_valid),
    .cq_ready (cq_ready),
    .cq_cmd   (cq_cmd)
  );

  bbq_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .STACK_DEPTH (STACK_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .root     (root),
    .cq_valid (cq_valid),
    .cq_ready (cq_ready),
    .cq_cmd   (cq_cmd),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire
